// File: src/stereo_position_panner_unit_defines.svh
// assertion macros used by the checker file spp_checker.sv
`ifndef STEREO_POSITION_PANNER_UNIT_DEFINES_SVH
`define STEREO_POSITION_PANNER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent, outside reset
`define SPP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("panner check failed");

// consequent must hold in the cycle after the antecedent, outside reset
`define SPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("panner check failed");

// consequent must hold in the cycle after the antecedent, reset included
`define SPP_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("panner check failed");

`endif

// File: src/spp_pkg.sv
`default_nettype none
package spp_pkg;

    localparam int CORDIC_ITERS = 24;
    localparam int TERMS        = 10;

    localparam logic [29:0] KINV_Q30     = 30'd652032874;
    localparam logic [30:0] ONE_Q30      = 31'd1073741824;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

    localparam logic [29:0] ATAN_TAB [0:CORDIC_ITERS-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
        30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
        30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    // coefficient sequencer states
    typedef enum logic [3:0] {
        CS_IDLE,
        CS_START,
        CS_VEC,
        CS_MAG_LO,
        CS_MAG_HI,
        CS_ROT_INIT,
        CS_ROT,
        CS_EXP_MUL,
        CS_EXP_DIV,
        CS_EXP_COR,
        CS_SQ1,
        CS_SQ2
    } spp_cstate_t;

    typedef struct packed {
        logic signed [15:0] gain_l;
        logic signed [15:0] gain_r;
        logic [30:0]        atten;
    } spp_coef_t;

    // floor(2^32-1 / k), quotient estimate is at most one low
    function automatic logic [31:0] spp_recip(input logic [3:0] k);
        logic [31:0] m;
        begin
            case (k)
                4'd1:    m = 32'd4294967295;
                4'd2:    m = 32'd2147483647;
                4'd3:    m = 32'd1431655765;
                4'd4:    m = 32'd1073741823;
                4'd5:    m = 32'd858993459;
                4'd6:    m = 32'd715827882;
                4'd7:    m = 32'd613566756;
                4'd8:    m = 32'd536870911;
                4'd9:    m = 32'd477218588;
                4'd10:   m = 32'd429496729;
                default: m = 32'd0;
            endcase
            return m;
        end
    endfunction

    // q30 to q1.15, round half up, saturate
    function automatic logic signed [15:0] spp_to_gain(input logic signed [32:0] c);
        logic signed [32:0] t;
        logic signed [17:0] g;
        logic signed [15:0] r;
        begin
            t = c + 33'sd16384;
            g = t[32:15];
            if (g > 18'sd32767) begin
                r = 16'sd32767;
            end else if (g < -18'sd32768) begin
                r = -16'sd32768;
            end else begin
                r = g[15:0];
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// File: src/stereo_position_panner_unit.sv
`default_nettype none
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    s_sample_in
// m_        out  m_valid/m_ready    m_left_out, m_right_out
// apb       in   psel/penable/...   pos_x at 0x0, pos_y at 0x4
//
// three-stage sample pipeline, one request per cycle while not stalled
// gains and attenuation come from a cordic/series sequencer after a register
// write; it skips vectoring when the position is the origin (as after reset)
// s_ready stays low while the sequencer runs
// a stall at m_ready freezes every stage; nothing is dropped or repeated
module stereo_position_panner_unit import spp_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_sample_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_left_out,
    output logic signed [15:0]      m_right_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic signed [15:0] pos_x_reg, pos_y_reg;
    logic               cfg_wr;
    spp_coef_t          coef;
    logic               coef_ready;
    logic               adv;

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [31:0] p1_reg [0:1];
    logic               n2_reg [0:1];
    logic [40:0]        m2_reg [0:1];
    logic signed [15:0] o3_reg [0:1];

    logic signed [15:0] gain [0:1];
    logic [30:0]        mag1 [0:1];
    logic [61:0]        prod2 [0:1];
    logic [40:0]        m40c [0:1];
    logic [55:0]        prod3 [0:1];
    logic [15:0]        mag3 [0:1];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? {16'b0, pos_y_reg} : {16'b0, pos_x_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= 16'sd0;
            pos_y_reg <= 16'sd0;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                pos_y_reg <= pwdata[15:0];
            end else begin
                pos_x_reg <= pwdata[15:0];
            end
        end
    end

    spp_coef u_coef (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (cfg_wr),
        .pos_x      (pos_x_reg),
        .pos_y      (pos_y_reg),
        .coef       (coef),
        .coef_ready (coef_ready)
    );

    assign adv     = !v3_reg || m_ready;
    assign s_ready = adv && coef_ready;
    assign gain[0] = coef.gain_l;
    assign gain[1] = coef.gain_r;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            mag1[i]  = p1_reg[i][31] ? 31'(-p1_reg[i]) : p1_reg[i][30:0];
            prod2[i] = mag1[i] * coef.atten;
            // q60 down to q40, clamp at one
            m40c[i]  = (prod2[i][61:20] > 42'h100_0000_0000) ? 41'h100_0000_0000
                                                             : prod2[i][60:20];
            prod3[i] = {m2_reg[i], 15'b0} - {15'b0, m2_reg[i]};
            mag3[i]  = prod3[i][55:40];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid && s_ready;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (adv) begin
            for (int i = 0; i < 2; i++) begin
                p1_reg[i] <= s_sample_in * gain[i];
                n2_reg[i] <= p1_reg[i][31];
                m2_reg[i] <= m40c[i];
                o3_reg[i] <= n2_reg[i] ? -signed'(mag3[i]) : signed'(mag3[i]);
            end
        end
    end

    assign m_valid     = v3_reg;
    assign m_left_out  = o3_reg[0];
    assign m_right_out = o3_reg[1];

endmodule
`default_nettype wire

// File: src/spp_coef.sv
`default_nettype none
module spp_coef import spp_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    output spp_coef_t               coef,
    output logic                    coef_ready
);

    spp_cstate_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [3:0]  k_reg, k_next;
    logic signed [34:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [33:0] ang_reg, ang_next;
    logic [63:0] acc_reg, acc_next;
    logic [29:0] u_reg, u_next;
    logic signed [32:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [33:0] z_reg, z_next;
    logic signed [15:0] gl_reg, gl_next, gr_reg, gr_next;
    logic [30:0] e_reg, e_next, e2_reg, e2_next, a_reg, a_next;
    logic [29:0] v_reg, v_next, q0_reg, q0_next;

    logic signed [34:0] vdx, vdy;
    logic signed [32:0] rdx, rdy;
    logic signed [33:0] atan_s;
    logic signed [34:0] x_ext, y_ext;
    logic [46:0] mul_lo, mul_hi;
    logic [63:0] mag_sum;
    logic signed [33:0] theta_sum, theta;
    logic [60:0] hprod;
    logic [61:0] dprod;
    logic [33:0] qk;
    logic [29:0] rem;
    logic [30:0] q;
    logic [61:0] sq1, sq2;

    assign vdx    = vy_reg >>> cnt_reg;
    assign vdy    = vx_reg >>> cnt_reg;
    assign rdx    = cy_reg >>> cnt_reg;
    assign rdy    = cx_reg >>> cnt_reg;
    assign atan_s = signed'({4'b0, ATAN_TAB[cnt_reg]});
    assign x_ext  = {{3{pos_x[15]}}, pos_x, 16'b0};
    assign y_ext  = {{3{pos_y[15]}}, pos_y, 16'b0};
    assign mul_lo = vx_reg[16:0] * KINV_Q30;
    assign mul_hi = vx_reg[33:17] * KINV_Q30;
    assign mag_sum = acc_reg + {mul_hi, 17'b0};
    assign theta_sum = ang_reg + QUARTER_TURN;
    assign theta  = theta_sum >>> 1;
    assign hprod  = u_reg * e_reg;
    assign dprod  = v_reg * spp_recip(k_reg);
    assign qk     = q0_reg * k_reg;
    assign rem    = v_reg - qk[29:0];
    assign q      = {1'b0, q0_reg} + ((rem >= {26'b0, k_reg}) ? 31'd1 : 31'd0);
    assign sq1    = e_reg * e_reg;
    assign sq2    = e2_reg * e2_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:     state_next = CS_IDLE;
            CS_START:    state_next = (pos_x == 16'sd0 && pos_y == 16'sd0) ? CS_ROT_INIT : CS_VEC;
            CS_VEC:      state_next = (cnt_reg == 5'(CORDIC_ITERS - 1)) ? CS_MAG_LO : CS_VEC;
            CS_MAG_LO:   state_next = CS_MAG_HI;
            CS_MAG_HI:   state_next = CS_ROT_INIT;
            CS_ROT_INIT: state_next = CS_ROT;
            CS_ROT:      state_next = (cnt_reg == 5'(CORDIC_ITERS - 1)) ? CS_EXP_MUL : CS_ROT;
            CS_EXP_MUL:  state_next = CS_EXP_DIV;
            CS_EXP_DIV:  state_next = CS_EXP_COR;
            CS_EXP_COR:  state_next = (k_reg == 4'd1) ? CS_SQ1 : CS_EXP_MUL;
            CS_SQ1:      state_next = CS_SQ2;
            CS_SQ2:      state_next = CS_IDLE;
            default:     state_next = CS_IDLE;
        endcase
        if (start) begin
            state_next = CS_START;
        end
    end

    // datapath
    always_comb begin
        cnt_next = cnt_reg;
        k_next   = k_reg;
        vx_next  = vx_reg;
        vy_next  = vy_reg;
        ang_next = ang_reg;
        acc_next = acc_reg;
        u_next   = u_reg;
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        z_next   = z_reg;
        gl_next  = gl_reg;
        gr_next  = gr_reg;
        e_next   = e_reg;
        e2_next  = e2_reg;
        a_next   = a_reg;
        v_next   = v_reg;
        q0_next  = q0_reg;
        case (state_reg)
            CS_START: begin
                cnt_next = 5'd0;
                ang_next = 34'sd0;
                u_next   = 30'd0;
                vx_next  = x_ext;
                vy_next  = y_ext;
                if (x_ext < 0) begin
                    ang_next = (y_ext >= 0) ? HALF_TURN : -HALF_TURN;
                    vx_next  = -x_ext;
                    vy_next  = -y_ext;
                end
            end
            CS_VEC: begin
                cnt_next = cnt_reg + 5'd1;
                if (!vy_reg[34]) begin
                    vx_next  = vx_reg + vdx;
                    vy_next  = vy_reg - vdy;
                    ang_next = ang_reg + atan_s;
                end else begin
                    vx_next  = vx_reg - vdx;
                    vy_next  = vy_reg + vdy;
                    ang_next = ang_reg - atan_s;
                end
            end
            CS_MAG_LO: acc_next = {17'b0, mul_lo};
            // r >> 2 taken straight from the q61 product
            CS_MAG_HI: u_next = mag_sum[61:32];
            CS_ROT_INIT: begin
                cnt_next = 5'd0;
                if (theta > QUARTER_TURN) begin
                    cx_next = 33'sd0;
                    cy_next = signed'({3'b0, KINV_Q30});
                    z_next  = theta - QUARTER_TURN;
                end else begin
                    cx_next = signed'({3'b0, KINV_Q30});
                    cy_next = 33'sd0;
                    z_next  = theta;
                end
            end
            CS_ROT: begin
                cnt_next = cnt_reg + 5'd1;
                if (!z_reg[33]) begin
                    cx_next = cx_reg - rdx;
                    cy_next = cy_reg + rdy;
                    z_next  = z_reg - atan_s;
                end else begin
                    cx_next = cx_reg + rdx;
                    cy_next = cy_reg - rdy;
                    z_next  = z_reg + atan_s;
                end
                if (cnt_reg == 5'(CORDIC_ITERS - 1)) begin
                    k_next = 4'(TERMS);
                    e_next = ONE_Q30;
                end
            end
            CS_EXP_MUL: v_next  = hprod[59:30];
            CS_EXP_DIV: q0_next = dprod[61:32];
            CS_EXP_COR: begin
                e_next = (q > ONE_Q30) ? 31'd0 : ONE_Q30 - q;
                k_next = k_reg - 4'd1;
            end
            CS_SQ1: begin
                e2_next = sq1[60:30];
                gl_next = spp_to_gain(cx_reg);
                gr_next = spp_to_gain(cy_reg);
            end
            CS_SQ2:  a_next = sq2[60:30];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_START;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg <= cnt_next;
        k_reg   <= k_next;
        vx_reg  <= vx_next;
        vy_reg  <= vy_next;
        ang_reg <= ang_next;
        acc_reg <= acc_next;
        u_reg   <= u_next;
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        z_reg   <= z_next;
        gl_reg  <= gl_next;
        gr_reg  <= gr_next;
        e_reg   <= e_next;
        e2_reg  <= e2_next;
        a_reg   <= a_next;
        v_reg   <= v_next;
        q0_reg  <= q0_next;
    end

    assign coef.gain_l = gl_reg;
    assign coef.gain_r = gr_reg;
    assign coef.atten  = a_reg;
    assign coef_ready  = (state_reg == CS_IDLE);

endmodule
`default_nettype wire

// File: src/spp_checker.sv
`default_nettype none
`include "stereo_position_panner_unit_defines.svh"
module spp_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [15:0] m_left_out,
    input wire logic signed [15:0] m_right_out,
    input wire logic               psel,
    input wire logic               penable,
    input wire logic               pwrite,
    input wire logic               pready
);

    // outputs are clamped to plus or minus full scale
    `SPP_ASSERT_NOW(a_out_range, aclk, aresetn, m_valid, (m_left_out != 16'sh8000 && m_right_out != 16'sh8000))

    // a register write reloads the coefficients, so input stalls
    `SPP_ASSERT_NEXT(a_cfg_stall, aclk, aresetn, (psel && penable && pwrite && pready), !s_ready)

    // a stalled result holds
    `SPP_ASSERT_NEXT(a_out_hold, aclk, aresetn, (m_valid && !m_ready), (m_valid && $stable(m_left_out) && $stable(m_right_out)))

    // reset empties the pipeline and starts the coefficient pass
    `SPP_ASSERT_ALWAYS_NEXT(a_reset, aclk, !aresetn, (!m_valid && !s_ready))

endmodule

bind stereo_position_panner_unit spp_checker u_spp_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_left_out  (m_left_out),
    .m_right_out (m_right_out),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready)
);
`default_nettype wire

// File: tb/stereo_position_panner_unit_test.sv
`default_nettype none
module stereo_position_panner_unit_test;
    import spp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] ADDR_POS_X = 3'd0;
    localparam logic [2:0] ADDR_POS_Y = 3'd4;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_sample_in = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_left_out;
    logic signed [15:0] m_right_out;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } stereo_pair_t;

    stereo_pair_t pending_pairs[$];
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;
    bit           hold_sink = 1'b0;
    bit           sink_long_hold = 1'b0;
    bit           no_gaps = 1'b0;

    // panner gains and attenuation for the current position
    logic signed [15:0] gain_left;
    logic signed [15:0] gain_right;
    logic [63:0]        atten_q30;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;

    stereo_position_panner_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample_in(s_sample_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_left_out(m_left_out), .m_right_out(m_right_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic longint floor_shr(input longint v, input int s);
        if (v >= 0) return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    function automatic logic signed [15:0] q30_to_gain(input longint q);
        longint g;
        g = floor_shr(q + (64'sd1 <<< 14), 15);
        if (g > 32767) g = 32767;
        if (g < -32768) g = -32768;
        return g[15:0];
    endfunction

    function automatic longint atan_entry(input int i);
        return longint'(ATAN_TAB[i]);
    endfunction

    task automatic compute_panning();
        longint vx, vy, ang, r, theta, cx, cy, z, dx, dy, u, e, e2;
        ang = 0;
        r = 0;
        if (cur_x != 0 || cur_y != 0) begin
            vx = longint'(cur_x) * 65536;
            vy = longint'(cur_y) * 65536;
            if (vx < 0) begin
                ang = (vy >= 0) ? 64'sd2147483648 : -64'sd2147483648;
                vx = -vx;
                vy = -vy;
            end
            for (int i = 0; i < CORDIC_ITERS; i++) begin
                dx = floor_shr(vy, i);
                dy = floor_shr(vx, i);
                if (vy >= 0) begin
                    vx += dx; vy -= dy; ang += atan_entry(i);
                end else begin
                    vx -= dx; vy += dy; ang -= atan_entry(i);
                end
            end
            r = floor_shr(vx * 64'sd652032874, 30);
            if (r < 0) r = 0;
        end
        theta = floor_shr(ang + 64'sd1073741824, 1);
        if (theta > 64'sd1073741824) begin
            cx = 0; cy = 64'sd652032874; z = theta - 64'sd1073741824;
        end else begin
            cx = 64'sd652032874; cy = 0; z = theta;
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            dx = floor_shr(cy, i);
            dy = floor_shr(cx, i);
            if (z >= 0) begin
                cx -= dx; cy += dy; z -= atan_entry(i);
            end else begin
                cx += dx; cy -= dy; z += atan_entry(i);
            end
        end
        gain_left = q30_to_gain(cx);
        gain_right = q30_to_gain(cy);
        // exp(-r/2) by horner series, r is value * 2^31
        u = r >>> 2;
        e = 64'sd1073741824;
        for (int k = 10; k >= 1; k--) begin
            e = 64'sd1073741824 - ((u * e) >>> 30) / k;
            if (e < 0) e = 0;
        end
        e2 = (e * e) >>> 30;
        atten_q30 = (e2 * e2) >>> 30;
    endtask

    function automatic logic signed [15:0] scale_channel(input logic signed [15:0] s,
                                                          input logic signed [15:0] g);
        longint      p;
        logic [63:0] m;
        logic [63:0] m40;
        logic [63:0] mag;
        bit          neg;
        p = longint'(s) * longint'(g);
        neg = p < 0;
        m = (neg ? -p : p) * atten_q30;
        m40 = m >> 20;
        if (m40 > (64'd1 << 40)) m40 = 64'd1 << 40;
        mag = (m40 * 64'd32767) >> 40;
        return neg ? -$signed(mag[15:0]) : $signed(mag[15:0]);
    endfunction

    task automatic wait_cycles(input int n);
        repeat (n) @(posedge aclk);
    endtask

    task automatic write_position(input logic [2:0] addr, input logic signed [15:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr;
        pwdata <= {{16{v[15]}}, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_POS_X) cur_x = v;
        else cur_y = v;
        compute_panning();
    endtask

    // drain before moving the source
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge aclk);
        wait_cycles(8);
    endtask

    task automatic set_position(input logic signed [15:0] x, input logic signed [15:0] y);
        drain_results();
        write_position(ADDR_POS_X, x);
        write_position(ADDR_POS_Y, y);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [15:0] s);
        int gap;
        stereo_pair_t p;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_in <= s;
        do @(posedge aclk); while (!s_ready);
        p.left = scale_channel(s, gain_left);
        p.right = scale_channel(s, gain_right);
        pending_pairs.push_back(p);
    endtask

    // sink side: checks each accepted result; random stalls and an optional long hold are driven below
    always @(posedge aclk) begin
        stereo_pair_t p;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pairs.size() == 0) begin
                $display("%0t unexpected result left %0d right %0d",
                         $time, m_left_out, m_right_out);
                error_count++;
            end else begin
                p = pending_pairs.pop_front();
                if (p.left !== m_left_out) begin
                    $display("%0t left mismatch: expected %0d actual %0d",
                             $time, p.left, m_left_out);
                    error_count++;
                end
                if (p.right !== m_right_out) begin
                    $display("%0t right mismatch: expected %0d actual %0d",
                             $time, p.right, m_right_out);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (sink_long_hold) begin
                m_ready <= 1'b0;
                repeat (60) @(posedge aclk);
                sink_long_hold = 1'b0;
            end
            stall = (hold_sink || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (stall == 0) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    task automatic test_origin_extremes();
        logic signed [15:0] edge_vals[6];
        edge_vals = '{16'sh7fff, -16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sh4000};
        cur_x = 0; cur_y = 0;
        compute_panning();
        foreach (edge_vals[i]) send_sample(edge_vals[i]);
    endtask

    task automatic test_special_positions();
        logic signed [15:0] px[8];
        logic signed [15:0] py[8];
        px = '{-16'sh8000, 16'sh7fff, 16'sd0, 16'sd0, -16'sh8000, -16'sd100,
               16'sh7fff, -16'sh4000};
        py = '{16'sd0, 16'sd0, 16'sh7fff, -16'sh8000, -16'sh8000, -16'sd1,
               16'sh7fff, 16'sh2000};
        foreach (px[i]) begin
            set_position(px[i], py[i]);
            send_sample(16'sh7fff);
            send_sample(-16'sh8000);
        end
    endtask

    task automatic test_random_positions();
        for (int n = 0; n < 70; n++) begin
            case ($urandom_range(0, 3))
                0: set_position(16'($urandom), 16'($urandom));
                1: set_position($urandom_range(0, 1) ? 16'sh7fff : -16'sh8000,
                                16'($urandom));
                default: set_position(16'($urandom_range(0, 255) - 128), 16'($urandom));
            endcase
            no_gaps = (n % 9 == 4);
            for (int j = 0; j < 24; j++) send_sample(16'($urandom));
            no_gaps = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        sink_long_hold = 1'b1;
        no_gaps = 1'b1;
        for (int j = 0; j < 40; j++) send_sample(16'($urandom));
        no_gaps = 1'b0;
        // sender waits for a full drain, then resumes
        drain_results();
        hold_sink = 1'b1;
        for (int j = 0; j < 20; j++) send_sample(16'($urandom));
        hold_sink = 1'b0;
    endtask

    initial begin
        cur_x = 0; cur_y = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_origin_extremes();
        test_special_positions();
        test_random_positions();
        test_backpressure();
        drain_results();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: stereo_position_panner_unit.f
+incdir+src
src/spp_pkg.sv
src/spp_coef.sv
src/stereo_position_panner_unit.sv
src/spp_checker.sv
tb/stereo_position_panner_unit_test.sv
